[rtl/cglg_pkg.sv]
// ----------------------------------------------------------------------------
// cglg_pkg
// Shared constants, types and helpers of the color grading table entry
// generator: Q1.16 constants, preset codes, normalize table, stage records.
// ----------------------------------------------------------------------------
`default_nettype none

package cglg_pkg;

	// Grid and field geometry
	localparam int GRID_POINTS = 32;
	localparam int GRID_MAX    = GRID_POINTS - 1;
	localparam int IDX_W       = 5;
	localparam int IDX_N       = 2 ** IDX_W;
	localparam int ADDR_W      = 15;
	localparam int BYTE_W      = 8;
	localparam int PRESET_W    = 3;

	// Datapath widths: Q1.16 value, full product, rounded product
	localparam int VAL_W  = 17;
	localparam int PROD_W = 35;
	localparam int WIDE_W = PROD_W - 16;
	localparam int SLOPE_W = 18;

	typedef logic [VAL_W-1:0]   q16_t;
	typedef logic [PROD_W-1:0]  prod_w_t;
	typedef logic [WIDE_W-1:0]  wide_t;
	typedef logic [SLOPE_W-1:0] slope_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [BYTE_W-1:0]  byte_t;
	typedef logic [PRESET_W-1:0] preset_t;

	// Preset codes
	localparam preset_t PRESET_NEUTRAL    = 3'd0;
	localparam preset_t PRESET_WARM       = 3'd1;
	localparam preset_t PRESET_COOL       = 3'd2;
	localparam preset_t PRESET_CONTRAST   = 3'd3;
	localparam preset_t PRESET_DESATURATE = 3'd4;

	// Q1.16 constants
	localparam q16_t ONE_Q16 = 17'd65536;
	localparam q16_t K_1_05  = 17'd68813;
	localparam q16_t K_0_85  = 17'd55706;
	localparam q16_t K_0_95  = 17'd62259;
	localparam q16_t K_1_10  = 17'd72090;
	localparam q16_t K_0_02  = 17'd1311;
	localparam q16_t K_0_03  = 17'd1966;
	localparam q16_t LUM_R   = 17'd13933;
	localparam q16_t LUM_G   = 17'd46872;
	localparam q16_t LUM_B   = 17'd4732;
	localparam prod_w_t HALF_LSB = 35'd32768;
	localparam slope_t THREE_Q16 = 18'd196608;

	// Channel slots
	localparam int CH_R = 0;
	localparam int CH_G = 1;
	localparam int CH_B = 2;

	// Normalize table: index to Q1.16, rounded to nearest
	typedef q16_t norm_tbl_t [IDX_N];

	function automatic norm_tbl_t build_norm();
		norm_tbl_t t;
		int        ii;
		for (int i = 0; i < IDX_N; i++) begin
			ii = (i > GRID_MAX) ? GRID_MAX : i;
			t[i] = VAL_W'((ii * 65536 + GRID_MAX / 2) / GRID_MAX);
		end
		return t;
	endfunction

	localparam norm_tbl_t NORM_TBL = build_norm();

	// Round a product back to Q1.16 scale, ties up
	function automatic wide_t rnd(prod_w_t p);
		prod_w_t s;
		s = p + HALF_LSB;
		return s[PROD_W-1:16];
	endfunction

	// Clamp to 1.0
	function automatic q16_t clamp_hi(wide_t v);
		return (v > WIDE_W'(ONE_Q16)) ? ONE_Q16 : v[VAL_W-1:0];
	endfunction

	function automatic wide_t widen(q16_t v);
		return WIDE_W'(v);
	endfunction

	// Stage records
	typedef struct packed {
		logic          valid;
		q16_t [2:0]    ch;
		addr_t         addr;
	} pix_t;

	typedef struct packed {
		logic          valid;
		q16_t [2:0]    ch;
		prod_w_t [2:0] prod;
		addr_t         addr;
	} prod_rec_t;

	typedef struct packed {
		logic          valid;
		q16_t [2:0]    ch;
		q16_t [2:0]    sm;
		addr_t         addr;
	} smooth_rec_t;

	typedef struct packed {
		logic          valid;
		byte_t [2:0]   px;
		addr_t         addr;
	} result_t;

endpackage

`default_nettype wire

[rtl/color_grading_lut_entry_generator_unit.sv]
// ----------------------------------------------------------------------------
// color_grading_lut_entry_generator_unit
// Turns one grid point of a color grading cube into graded bytes and the
// linear entry address.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive red_index, green_index, blue_index and raise
//   start; the beat is taken at each rising edge with start high and busy
//   low. busy stays low, so a new beat may be issued every cycle.
//   Result channel: done is high for one cycle with red_out, green_out,
//   blue_out and entry_address; the beat is taken at the end of that cycle.
//   The throughput is one entry per cycle, through six register stages
//   (normalize, gain multiply, offset and mix, square, smoothstep product,
//   byte round), each holding one multiply or add and clamp.
//   Configuration: cfg_data carries preset_select; a beat is taken when
//   cfg_valid and cfg_ready are high. cfg_ready is always high. Write it
//   only with no entry in flight.
//   Reset clears the valid bits of all stages and sets the preset to
//   neutral. The receiver has no stall input, so no results are held back.
// ----------------------------------------------------------------------------
`default_nettype none

module color_grading_lut_entry_generator_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [cglg_pkg::IDX_W-1:0]     red_index,
	input  wire logic [cglg_pkg::IDX_W-1:0]     green_index,
	input  wire logic [cglg_pkg::IDX_W-1:0]     blue_index,
	output logic                                done,
	output logic [cglg_pkg::BYTE_W-1:0]         red_out,
	output logic [cglg_pkg::BYTE_W-1:0]         green_out,
	output logic [cglg_pkg::BYTE_W-1:0]         blue_out,
	output logic [cglg_pkg::ADDR_W-1:0]         entry_address,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [cglg_pkg::PRESET_W-1:0]  cfg_data
);

	cglg_pkg::preset_t     preset_q;
	cglg_pkg::pix_t        pix_s1;
	cglg_pkg::pix_t        pix_s3;
	cglg_pkg::smooth_rec_t rec_s5;
	cglg_pkg::result_t     res_s6;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Hold the preset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preset_q <= cglg_pkg::PRESET_NEUTRAL;
		end else if (cfg_valid && cfg_ready) begin
			preset_q <= cfg_data;
		end
	end

	cglg_normalize u_normalize (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (start && !busy),
		.red_index   (red_index),
		.green_index (green_index),
		.blue_index  (blue_index),
		.pix_s1      (pix_s1)
	);

	cglg_grade u_grade (
		.clk    (clk),
		.arst_n (arst_n),
		.preset (preset_q),
		.pix_s1 (pix_s1),
		.pix_s3 (pix_s3)
	);

	cglg_smooth u_smooth (
		.clk    (clk),
		.arst_n (arst_n),
		.pix_s3 (pix_s3),
		.rec_s5 (rec_s5)
	);

	cglg_quantize u_quantize (
		.clk    (clk),
		.arst_n (arst_n),
		.preset (preset_q),
		.rec_s5 (rec_s5),
		.res_s6 (res_s6)
	);

	// Drive the result beat
	assign done          = res_s6.valid;
	assign red_out       = res_s6.px[cglg_pkg::CH_R];
	assign green_out     = res_s6.px[cglg_pkg::CH_G];
	assign blue_out      = res_s6.px[cglg_pkg::CH_B];
	assign entry_address = res_s6.addr;

`ifndef SYNTH
	// Every command beat comes out as a result beat
	a_cmd_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##6 done)
		else $error("command beat did not produce a result");

	// No result without an earlier command beat
	a_done_from_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 6))
		else $error("result beat without a command beat");
`endif

endmodule

`default_nettype wire

[rtl/cglg_normalize.sv]
// ----------------------------------------------------------------------------
// cglg_normalize
// Stage 1: saturate grid indices, look up Q1.16 coordinates, form the
// linear entry address.
// ----------------------------------------------------------------------------
`default_nettype none

module cglg_normalize (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic [cglg_pkg::IDX_W-1:0]    red_index,
	input  wire logic [cglg_pkg::IDX_W-1:0]    green_index,
	input  wire logic [cglg_pkg::IDX_W-1:0]    blue_index,
	output cglg_pkg::pix_t                     pix_s1
);

	logic [cglg_pkg::IDX_W-1:0] ri, gi, bi;
	cglg_pkg::addr_t            addr;

	// Saturate each index to the top grid point
	always_comb begin
		ri = (int'(red_index) > cglg_pkg::GRID_MAX) ?
			cglg_pkg::IDX_W'(cglg_pkg::GRID_MAX) : red_index;
		gi = (int'(green_index) > cglg_pkg::GRID_MAX) ?
			cglg_pkg::IDX_W'(cglg_pkg::GRID_MAX) : green_index;
		bi = (int'(blue_index) > cglg_pkg::GRID_MAX) ?
			cglg_pkg::IDX_W'(cglg_pkg::GRID_MAX) : blue_index;
		addr = cglg_pkg::ADDR_W'(int'(bi) * cglg_pkg::GRID_POINTS * cglg_pkg::GRID_POINTS
			+ int'(gi) * cglg_pkg::GRID_POINTS + int'(ri));
	end

	// Advance the valid bit and capture the payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s1 <= '0;
		end else begin
			pix_s1.valid              <= in_valid;
			pix_s1.ch[cglg_pkg::CH_R] <= cglg_pkg::NORM_TBL[ri];
			pix_s1.ch[cglg_pkg::CH_G] <= cglg_pkg::NORM_TBL[gi];
			pix_s1.ch[cglg_pkg::CH_B] <= cglg_pkg::NORM_TBL[bi];
			pix_s1.addr               <= addr;
		end
	end

endmodule

`default_nettype wire

[rtl/cglg_grade.sv]
// ----------------------------------------------------------------------------
// cglg_grade
// Stages 2 and 3: per-channel gain multiply, then offsets, clamps and the
// luminance mix of the selected preset.
// ----------------------------------------------------------------------------
`default_nettype none

module cglg_grade (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cglg_pkg::preset_t preset,
	input  wire cglg_pkg::pix_t    pix_s1,
	output cglg_pkg::pix_t         pix_s3
);

	cglg_pkg::q16_t [2:0]   gain;
	cglg_pkg::prod_rec_t    rec_s2;
	cglg_pkg::q16_t [2:0]   adj;
	cglg_pkg::wide_t        t_r, t_g, t_b;
	logic [cglg_pkg::PROD_W:0] lum_sum;
	cglg_pkg::wide_t        lum;
	logic [cglg_pkg::WIDE_W:0] mix [3];

	// Pick the per-channel gain of the preset
	always_comb begin
		case (preset)
			cglg_pkg::PRESET_WARM: begin
				gain = {cglg_pkg::K_0_85, cglg_pkg::ONE_Q16, cglg_pkg::K_1_05};
			end
			cglg_pkg::PRESET_COOL: begin
				gain = {cglg_pkg::K_1_10, cglg_pkg::K_0_95, cglg_pkg::K_0_85};
			end
			cglg_pkg::PRESET_DESATURATE: begin
				gain = {cglg_pkg::LUM_B, cglg_pkg::LUM_G, cglg_pkg::LUM_R};
			end
			default: begin
				gain = {cglg_pkg::ONE_Q16, cglg_pkg::ONE_Q16, cglg_pkg::ONE_Q16};
			end
		endcase
	end

	// Stage 2: multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_s2 <= '0;
		end else begin
			rec_s2.valid <= pix_s1.valid;
			for (int c = 0; c < 3; c++) begin
				rec_s2.prod[c] <= cglg_pkg::PROD_W'(pix_s1.ch[c])
					* cglg_pkg::PROD_W'(gain[c]);
			end
			rec_s2.ch   <= pix_s1.ch;
			rec_s2.addr <= pix_s1.addr;
		end
	end

	// Apply offsets, clamps and the luminance mix
	always_comb begin
		t_r = cglg_pkg::rnd(rec_s2.prod[cglg_pkg::CH_R]);
		t_g = cglg_pkg::rnd(rec_s2.prod[cglg_pkg::CH_G]);
		t_b = cglg_pkg::rnd(rec_s2.prod[cglg_pkg::CH_B]);
		lum_sum = (cglg_pkg::PROD_W+1)'(rec_s2.prod[cglg_pkg::CH_R])
			+ (cglg_pkg::PROD_W+1)'(rec_s2.prod[cglg_pkg::CH_G])
			+ (cglg_pkg::PROD_W+1)'(rec_s2.prod[cglg_pkg::CH_B])
			+ (cglg_pkg::PROD_W+1)'(cglg_pkg::HALF_LSB);
		lum = lum_sum[cglg_pkg::WIDE_W+15:16];
		for (int c = 0; c < 3; c++) begin
			mix[c] = (cglg_pkg::WIDE_W+1)'(lum) + (cglg_pkg::WIDE_W+1)'(rec_s2.ch[c])
				+ (cglg_pkg::WIDE_W+1)'(1);
		end
		case (preset)
			cglg_pkg::PRESET_WARM: begin
				adj[cglg_pkg::CH_R] = cglg_pkg::clamp_hi(t_r + cglg_pkg::widen(cglg_pkg::K_0_02));
				adj[cglg_pkg::CH_G] = rec_s2.ch[cglg_pkg::CH_G];
				adj[cglg_pkg::CH_B] = (t_b > cglg_pkg::widen(cglg_pkg::K_0_02)) ?
					cglg_pkg::clamp_hi(t_b - cglg_pkg::widen(cglg_pkg::K_0_02)) : '0;
			end
			cglg_pkg::PRESET_COOL: begin
				adj[cglg_pkg::CH_R] = cglg_pkg::clamp_hi(
					cglg_pkg::widen(cglg_pkg::clamp_hi(t_r))
					+ cglg_pkg::widen(cglg_pkg::K_0_02));
				adj[cglg_pkg::CH_G] = cglg_pkg::clamp_hi(
					cglg_pkg::widen(cglg_pkg::clamp_hi(t_g + cglg_pkg::widen(cglg_pkg::K_0_02)))
					+ cglg_pkg::widen(cglg_pkg::K_0_02));
				adj[cglg_pkg::CH_B] = cglg_pkg::clamp_hi(
					cglg_pkg::widen(cglg_pkg::clamp_hi(t_b + cglg_pkg::widen(cglg_pkg::K_0_03)))
					+ cglg_pkg::widen(cglg_pkg::K_0_02));
			end
			cglg_pkg::PRESET_DESATURATE: begin
				for (int c = 0; c < 3; c++) begin
					adj[c] = mix[c][cglg_pkg::VAL_W:1];
				end
			end
			default: begin
				adj = rec_s2.ch;
			end
		endcase
	end

	// Stage 3: hold the graded channels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s3 <= '0;
		end else begin
			pix_s3.valid <= rec_s2.valid;
			pix_s3.ch    <= adj;
			pix_s3.addr  <= rec_s2.addr;
		end
	end

endmodule

`default_nettype wire

[rtl/cglg_smooth.sv]
// ----------------------------------------------------------------------------
// cglg_smooth
// Stages 4 and 5: smoothstep x*x*(3-2x) per channel, one multiply a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cglg_smooth (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire cglg_pkg::pix_t  pix_s3,
	output cglg_pkg::smooth_rec_t rec_s5
);

	logic                    valid_s4;
	cglg_pkg::q16_t [2:0]    ch_s4;
	cglg_pkg::q16_t [2:0]    sq_s4;
	cglg_pkg::slope_t [2:0]  slope_s4;
	cglg_pkg::addr_t         addr_s4;
	cglg_pkg::wide_t [2:0]   sq_w;

	// Square term
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sq_w[c] = cglg_pkg::rnd(cglg_pkg::PROD_W'(pix_s3.ch[c])
				* cglg_pkg::PROD_W'(pix_s3.ch[c]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= pix_s3.valid;
		end
	end

	// Stage 4: square, 3 - 2x
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			sq_s4[c]    <= sq_w[c][cglg_pkg::VAL_W-1:0];
			slope_s4[c] <= cglg_pkg::THREE_Q16 - {pix_s3.ch[c], 1'b0};
		end
		ch_s4   <= pix_s3.ch;
		addr_s4 <= pix_s3.addr;
	end

	// Stage 5: final product, clamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_s5 <= '0;
		end else begin
			rec_s5.valid <= valid_s4;
			for (int c = 0; c < 3; c++) begin
				rec_s5.sm[c] <= cglg_pkg::clamp_hi(cglg_pkg::rnd(
					cglg_pkg::PROD_W'(sq_s4[c]) * cglg_pkg::PROD_W'(slope_s4[c])));
			end
			rec_s5.ch   <= ch_s4;
			rec_s5.addr <= addr_s4;
		end
	end

endmodule

`default_nettype wire

[rtl/cglg_quantize.sv]
// ----------------------------------------------------------------------------
// cglg_quantize
// Stage 6: choose the smoothed or plain value, clamp and round to bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module cglg_quantize (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cglg_pkg::preset_t     preset,
	input  wire cglg_pkg::smooth_rec_t rec_s5,
	output cglg_pkg::result_t          res_s6
);

	localparam int SCALE_W = cglg_pkg::VAL_W + cglg_pkg::BYTE_W;

	logic                 use_smooth;
	cglg_pkg::q16_t       v [3];
	logic [SCALE_W-1:0]   scaled [3];

	// Pick the curve output for warm and contrast, then v*255 rounded
	always_comb begin
		use_smooth = (preset == cglg_pkg::PRESET_WARM) ||
			(preset == cglg_pkg::PRESET_CONTRAST);
		for (int c = 0; c < 3; c++) begin
			v[c] = use_smooth ? rec_s5.sm[c] :
				cglg_pkg::clamp_hi(cglg_pkg::widen(rec_s5.ch[c]));
			scaled[c] = {v[c], 8'd0} - SCALE_W'(v[c]) + SCALE_W'(cglg_pkg::HALF_LSB);
		end
	end

	// Advance the valid bit and register the bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s6 <= '0;
		end else begin
			res_s6.valid <= rec_s5.valid;
			for (int c = 0; c < 3; c++) begin
				res_s6.px[c] <= scaled[c][23:16];
			end
			res_s6.addr <= rec_s5.addr;
		end
	end

endmodule

`default_nettype wire

[bench/color_grading_lut_entry_generator_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// color_grading_lut_entry_generator_unit_tb
// Self-checking bench for the color grading table entry generator. A queue of
// grid points feeds a clocked command driver with random gaps and bursts. A
// clocked monitor predicts each accepted entry at the preset in force, checks
// every done beat in order, and runs a quiet-cycle watchdog. The preset is
// rewritten between phases, only once all entries in flight have returned.
// ----------------------------------------------------------------------------

module color_grading_lut_entry_generator_unit_tb;

	// Spare preset codes, treated as neutral by the block
	localparam cglg_pkg::preset_t PRESET_SPARE_5 = 3'd5;
	localparam cglg_pkg::preset_t PRESET_SPARE_6 = 3'd6;
	localparam cglg_pkg::preset_t PRESET_SPARE_7 = 3'd7;

	// Grading constants in Q1.16
	localparam logic [63:0] Q_ONE    = 64'd65536;
	localparam logic [63:0] Q_HALF   = 64'd32768;
	localparam logic [63:0] G_1_05   = 64'd68813;
	localparam logic [63:0] G_0_85   = 64'd55706;
	localparam logic [63:0] G_0_95   = 64'd62259;
	localparam logic [63:0] G_1_10   = 64'd72090;
	localparam logic [63:0] LIFT_002 = 64'd1311;
	localparam logic [63:0] LIFT_003 = 64'd1966;
	localparam logic [63:0] Y_R      = 64'd13933;
	localparam logic [63:0] Y_G      = 64'd46872;
	localparam logic [63:0] Y_B      = 64'd4732;

	localparam int PHASES         = 15;
	localparam int DIRECTED_PHASES = 8;
	localparam int RAND_PER_PHASE = 122;
	localparam int QUIET_LIMIT    = 500;
	localparam int DRAIN_CYCLES   = 16;

	typedef struct packed {
		logic [cglg_pkg::IDX_W-1:0] red;
		logic [cglg_pkg::IDX_W-1:0] green;
		logic [cglg_pkg::IDX_W-1:0] blue;
	} grid_point_t;

	typedef struct packed {
		cglg_pkg::byte_t red;
		cglg_pkg::byte_t green;
		cglg_pkg::byte_t blue;
		cglg_pkg::addr_t addr;
	} graded_entry_t;

	logic                          clk         = 1'b0;
	logic                          arst_n      = 1'b0;
	logic                          start       = 1'b0;
	logic                          busy;
	logic [cglg_pkg::IDX_W-1:0]    red_index   = '0;
	logic [cglg_pkg::IDX_W-1:0]    green_index = '0;
	logic [cglg_pkg::IDX_W-1:0]    blue_index  = '0;
	logic                          done;
	cglg_pkg::byte_t               red_out;
	cglg_pkg::byte_t               green_out;
	cglg_pkg::byte_t               blue_out;
	cglg_pkg::addr_t               entry_address;
	logic                          cfg_valid   = 1'b0;
	logic                          cfg_ready;
	cglg_pkg::preset_t             cfg_data    = '0;

	grid_point_t         point_backlog [$];
	graded_entry_t       graded_q [$];
	grid_point_t         next_point;
	graded_entry_t       graded_now;
	graded_entry_t       graded_want;
	cglg_pkg::preset_t   grade_preset = cglg_pkg::PRESET_NEUTRAL;

	int unsigned         points_sent   = 0;
	int unsigned         points_taken  = 0;
	int unsigned         entries_seen  = 0;
	int unsigned         preset_writes = 0;
	int unsigned         mismatches    = 0;
	int unsigned         quiet_cycles  = 0;
	int unsigned         hold_off      = 0;
	int unsigned         burst_left    = 0;

	color_grading_lut_entry_generator_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.red_index     (red_index),
		.green_index   (green_index),
		.blue_index    (blue_index),
		.done          (done),
		.red_out       (red_out),
		.green_out     (green_out),
		.blue_out      (blue_out),
		.entry_address (entry_address),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #4 clk = ~clk;

	// Rounded Q1.16 product, ties up
	function automatic logic [63:0] qprod(logic [63:0] a, logic [63:0] b);
		return (a * b + Q_HALF) >> 16;
	endfunction

	function automatic logic [63:0] clamp_one(logic [63:0] v);
		return (v > Q_ONE) ? Q_ONE : v;
	endfunction

	function automatic logic [63:0] smoothstep(logic [63:0] x);
		logic [63:0] xc;
		xc = clamp_one(x);
		return clamp_one(qprod(qprod(xc, xc), 3 * Q_ONE - 2 * xc));
	endfunction

	function automatic cglg_pkg::byte_t to_byte(logic [63:0] v);
		logic [63:0] s;
		s = (clamp_one(v) * 64'd255 + Q_HALF) >> 16;
		return s[7:0];
	endfunction

	function automatic logic [63:0] sat_idx(logic [cglg_pkg::IDX_W-1:0] i);
		return (i > cglg_pkg::GRID_MAX) ? 64'(cglg_pkg::GRID_MAX) : 64'(i);
	endfunction

	function automatic logic [63:0] to_unit(logic [63:0] i);
		return (i * Q_ONE + cglg_pkg::GRID_MAX / 2) / cglg_pkg::GRID_MAX;
	endfunction

	// Predict one graded entry for a grid point under a preset
	function automatic graded_entry_t grade_entry(cglg_pkg::preset_t preset, grid_point_t p);
		graded_entry_t e;
		logic [63:0]   ri, gi, bi, r, g, b, t, lum, a;
		ri = sat_idx(p.red);
		gi = sat_idx(p.green);
		bi = sat_idx(p.blue);
		r  = to_unit(ri);
		g  = to_unit(gi);
		b  = to_unit(bi);
		case (preset)
			cglg_pkg::PRESET_WARM: begin
				r = clamp_one(qprod(r, G_1_05) + LIFT_002);
				t = qprod(b, G_0_85);
				b = (t > LIFT_002) ? clamp_one(t - LIFT_002) : 64'd0;
				r = smoothstep(r);
				g = smoothstep(g);
				b = smoothstep(b);
			end
			cglg_pkg::PRESET_COOL: begin
				r = clamp_one(qprod(r, G_0_85));
				g = clamp_one(qprod(g, G_0_95) + LIFT_002);
				b = clamp_one(qprod(b, G_1_10) + LIFT_003);
				r = clamp_one(r + LIFT_002);
				g = clamp_one(g + LIFT_002);
				b = clamp_one(b + LIFT_002);
			end
			cglg_pkg::PRESET_CONTRAST: begin
				r = smoothstep(r);
				g = smoothstep(g);
				b = smoothstep(b);
			end
			cglg_pkg::PRESET_DESATURATE: begin
				lum = (Y_R * r + Y_G * g + Y_B * b + Q_HALF) >> 16;
				r = (lum + r + 1) >> 1;
				g = (lum + g + 1) >> 1;
				b = (lum + b + 1) >> 1;
			end
			default: begin
			end
		endcase
		a = bi * cglg_pkg::GRID_POINTS * cglg_pkg::GRID_POINTS
			+ gi * cglg_pkg::GRID_POINTS + ri;
		e.red   = to_byte(r);
		e.green = to_byte(g);
		e.blue  = to_byte(b);
		e.addr  = a[cglg_pkg::ADDR_W-1:0];
		return e;
	endfunction

	// Command driver: hold a beat until taken, then idle or send the next point
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && points_taken != points_sent) begin
			start <= 1'b1;
		end else if (hold_off > 0) begin
			start    <= 1'b0;
			hold_off <= hold_off - 1;
		end else if (point_backlog.size() > 0) begin
			next_point  = point_backlog.pop_front();
			start       <= 1'b1;
			red_index   <= next_point.red;
			green_index <= next_point.green;
			blue_index  <= next_point.blue;
			points_sent <= points_sent + 1;
			// Draw the gap before the next point; bursts run with no gaps
			if (burst_left > 0) begin
				burst_left <= burst_left - 1;
				hold_off   <= 0;
			end else begin
				hold_off <= $urandom_range(0, 3);
				if ($urandom_range(0, 15) == 0)
					burst_left <= $urandom_range(16, 64);
			end
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor: check done beats, predict accepted points, track the preset
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				entries_seen <= entries_seen + 1;
				graded_now = '{red_out, green_out, blue_out, entry_address};
				if (graded_q.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("unexpected entry: r=%0d g=%0d b=%0d addr=%0d",
							red_out, green_out, blue_out, entry_address);
				end else begin
					graded_want = graded_q.pop_front();
					if (graded_now != graded_want) begin
						mismatches = mismatches + 1;
						if (mismatches <= 10)
							$display("mismatch addr exp=%0d got=%0d: r %0d/%0d g %0d/%0d b %0d/%0d",
								graded_want.addr, graded_now.addr,
								graded_want.red, graded_now.red,
								graded_want.green, graded_now.green,
								graded_want.blue, graded_now.blue);
					end
				end
			end
			if (start && !busy) begin
				graded_q.insert(graded_q.size(), grade_entry(grade_preset,
					'{red_index, green_index, blue_index}));
				points_taken <= points_taken + 1;
			end
			if (cfg_valid && cfg_ready)
				grade_preset = cfg_data;
			// Watchdog on cycles with no beat of any kind
			if (done || (start && !busy) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Wait until no point is queued, in flight or awaiting its entry
	task automatic wait_drained();
		while (point_backlog.size() != 0 || points_taken != points_sent || start ||
				graded_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_preset(cglg_pkg::preset_t value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		preset_writes = preset_writes + 1;
	endtask

	// Queue one grid point at the tail of the backlog
	task automatic queue_point(grid_point_t p);
		point_backlog.insert(point_backlog.size(), p);
	endtask

	// Pick a field value, leaning on the grid extremes now and then
	function automatic logic [cglg_pkg::IDX_W-1:0] pick_index();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? cglg_pkg::IDX_W'(cglg_pkg::GRID_MAX) : '0;
		return cglg_pkg::IDX_W'($urandom_range(0, cglg_pkg::IDX_N - 1));
	endfunction

	// Phase sequence: reset preset, every code once, back to neutral, then random
	initial begin
		cglg_pkg::preset_t phase_preset [PHASES];
		grid_point_t       mixed_pts [DIRECTED_PHASES];
		grid_point_t       p;
		phase_preset[0] = cglg_pkg::PRESET_NEUTRAL;
		phase_preset[1] = cglg_pkg::PRESET_WARM;
		phase_preset[2] = cglg_pkg::PRESET_COOL;
		phase_preset[3] = cglg_pkg::PRESET_CONTRAST;
		phase_preset[4] = cglg_pkg::PRESET_DESATURATE;
		phase_preset[5] = PRESET_SPARE_5;
		phase_preset[6] = PRESET_SPARE_6;
		phase_preset[7] = PRESET_SPARE_7;
		phase_preset[8] = cglg_pkg::PRESET_NEUTRAL;
		for (int k = 9; k < PHASES; k++)
			phase_preset[k] = cglg_pkg::PRESET_W'($urandom_range(0, 7));
		mixed_pts[0] = '{5'd31, 5'd0, 5'd16};
		mixed_pts[1] = '{5'd0, 5'd31, 5'd1};
		mixed_pts[2] = '{5'd16, 5'd8, 5'd31};
		mixed_pts[3] = '{5'd1, 5'd30, 5'd15};
		mixed_pts[4] = '{5'd31, 5'd31, 5'd0};
		mixed_pts[5] = '{5'd0, 5'd0, 5'd31};
		mixed_pts[6] = '{5'd10, 5'd20, 5'd5};
		mixed_pts[7] = '{5'd30, 5'd1, 5'd2};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int k = 0; k < PHASES; k++) begin
			if (k > 0) begin
				wait_drained();
				write_preset(phase_preset[k]);
			end
			if (k < DIRECTED_PHASES) begin
				queue_point('{5'd0, 5'd0, 5'd0});
				queue_point('{5'd31, 5'd31, 5'd31});
				queue_point(mixed_pts[k]);
			end
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				p.red   = pick_index();
				p.green = pick_index();
				p.blue  = pick_index();
				queue_point(p);
			end
		end

		// Drain, then wait for stray beats and count entries that never returned
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (graded_q.size() != 0) begin
			mismatches = mismatches + graded_q.size();
			$display("%0d entries never returned", graded_q.size());
		end

		$display("graded %0d grid points over %0d phases with %0d preset writes",
			entries_seen, PHASES, preset_writes);
		$display("all preset codes including spares, with gaps and back-to-back bursts");
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
